>>> rtl/bce_pkg.sv
// Shared types, constants and state codes of the betweenness centrality engine.
`timescale 1ns / 1ps
package bce_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_MAX_EDGES    = 8192;
   localparam int DEF_FRAC_BITS    = 16;

   // Fixed field and arithmetic widths.
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 13;
   localparam int VALUE_W  = 14;
   localparam int VERTEX_W = 10;
   localparam int CENT_W   = 36;
   localparam int CNT_W    = 32;
   localparam int DEP_W    = 40;
   localparam int OPA_W    = 41;
   localparam int PROD_W   = CNT_W + OPA_W;
   localparam int STEP_W   = $clog2(PROD_W);
   localparam int NUMV_W   = 11;
   localparam int SRC_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CNT_W-1:0]  CNT_MAX = '1;
   localparam logic [DEP_W-1:0]  DEP_MAX = '1;
   localparam logic [CENT_W-1:0] CEN_MAX = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_NUM_VERTICES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_SOURCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_SOURCE  = 2'd2;

   // Command codes of an input item.
   localparam logic [CMD_W-1:0] CMD_LOAD_OFFSET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_EDGE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ        = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [CENT_W-1:0]   centrality;
      logic                saturated;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_SOURCE,
      ST_INIT,
      ST_SEED,
      ST_B_POP,
      ST_B_VTX,
      ST_B_LO,
      ST_B_HI,
      ST_B_EDGE,
      ST_B_NBR,
      ST_B_UPD,
      ST_R_POP,
      ST_R_VTX,
      ST_R_LO,
      ST_R_HI,
      ST_R_EDGE,
      ST_R_NBR,
      ST_R_CHK,
      ST_MUL0,
      ST_MUL1,
      ST_DIV,
      ST_ACC,
      ST_R_CEN,
      ST_R_CENW
   } state_type;

endpackage

>>> rtl/bce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

>>> rtl/betweenness_centrality_engine_top.sv
// Top level of the betweenness centrality engine: sequencer, shared arithmetic and stores.
`timescale 1ns / 1ps
// A load item (row offset or edge target) leaves the block idle. A read item passes
// through the read state and then waits only for the result register to be free. A run
// item keeps the block busy: first a pass over all MAX_VERTICES entries clears the
// centrality store, then each source in range clears the per-vertex stores of the first
// n vertices, walks each visited vertex and its edges in the forward pass, and in the
// reverse pass walks each vertex and edge again, with extra work for each edge that lies
// on a shortest path: one 32x32 multiplier used twice and a restoring divider that
// yields one quotient bit per cycle over 73 steps. After reset the same clearing pass
// runs and no item is accepted until it ends; configuration writes are taken at any time.
module betweenness_centrality_engine_top
   import bce_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bce_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bce_pkg::rsp_type             rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [bce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bce_pkg::CSR_DATA_W-1:0] csr_data
);

   import bce_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int RAW = $clog2(MAX_VERTICES + 1);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int KCW = $clog2(MAX_EDGES + 1);
   localparam int KW  = (KCW > VALUE_W) ? KCW : VALUE_W;
   localparam int DW  = VCW;
   localparam logic [OPA_W-1:0] FIX_ONE = OPA_W'(1) << FRAC_BITS;

   // Control registers.
   state_type            state_ff, state_in;
   logic                 clr_run_ff, clr_run_in;
   logic [VCW-1:0]       cnt_ff, cnt_in;
   logic [SRC_W:0]       src_ff, src_in;
   logic [VCW-1:0]       head_ff, head_in;
   logic [VCW-1:0]       tail_ff, tail_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NUMV_W-1:0]    numv_ff, numv_in;
   logic [SRC_W-1:0]     first_ff, first_in;
   logic [SRC_W-1:0]     last_ff, last_in;

   // Datapath registers.
   logic [VW-1:0]        cur_ff, cur_in;
   logic [VW-1:0]        nbr_ff, nbr_in;
   logic [DW-1:0]        dcur_ff, dcur_in;
   logic [CNT_W-1:0]     pcur_ff, pcur_in;
   logic [DEP_W-1:0]     dep_cur_ff, dep_cur_in;
   logic [DEP_W-1:0]     dep_nbr_ff, dep_nbr_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [KW-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]     mul_ff, mul_in;
   logic [OPA_W-1:0]     opa_ff, opa_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DEP_W-1:0]     quo_ff, quo_in;
   logic                 qovf_ff, qovf_in;
   logic [VERTEX_W-1:0]  rd_vertex_ff, rd_vertex_in;
   logic                 rd_inrange_ff, rd_inrange_in;
   rsp_type              rsp_ff, rsp_in;

   // Memory ports.
   logic                 row_we, row_re;
   logic [RAW-1:0]       row_waddr, row_raddr;
   logic [VALUE_W-1:0]   row_wdata, row_rd;
   logic                 edge_we, edge_re;
   logic [EW-1:0]        edge_waddr, edge_raddr;
   logic [VALUE_W-1:0]   edge_wdata, edge_rd;
   logic                 path_we, path_re;
   logic [VW-1:0]        path_waddr, path_raddr;
   logic [CNT_W-1:0]     path_wdata, path_rd;
   logic                 dist_we, dist_re;
   logic [VW-1:0]        dist_waddr, dist_raddr;
   logic [DW:0]          dist_wdata, dist_rd;
   logic                 dep_we, dep_re;
   logic [VW-1:0]        dep_waddr, dep_raddr;
   logic [DEP_W-1:0]     dep_wdata, dep_rd;
   logic                 order_we, order_re;
   logic [VW-1:0]        order_waddr, order_raddr;
   logic [VW-1:0]        order_wdata, order_rd;
   logic                 cen_we, cen_re;
   logic [VW-1:0]        cen_waddr, cen_raddr;
   logic [CENT_W-1:0]    cen_wdata, cen_rd;

   // Combinational helpers.
   logic [VCW-1:0]       n_eff;
   logic                 req_accept;
   logic [CNT_W-1:0]     mul_b;
   logic [2*CNT_W-1:0]   mprod;
   logic [CNT_W:0]       div_trial;
   logic                 div_ge;
   logic [DW-1:0]        dnext;
   logic [DW-1:0]        dw_eff;
   logic [CNT_W:0]       psum;
   logic [DEP_W:0]       dsum;
   logic [DEP_W-1:0]     term;
   logic [DEP_W:0]       csum;

   // Effective vertex count, capped at the store depth.
   assign n_eff = (32'(numv_ff) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(numv_ff);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Shared multiplier: low operand word in the first pass, high bits in the second.
   assign mul_b = (state_ff == ST_MUL1) ? CNT_W'(opa_ff[OPA_W-1:CNT_W]) : opa_ff[CNT_W-1:0];
   assign mprod = {{CNT_W{1'b0}}, mul_ff} * {{CNT_W{1'b0}}, mul_b};

   // Restoring divider step: one quotient bit per cycle, divisor is sigma of the current vertex.
   assign div_trial = {rem_ff, prod_ff[PROD_W-1]};
   assign div_ge    = (div_trial >= {1'b0, pcur_ff});

   assign dnext  = DW'(dcur_ff + DW'(1));
   assign dw_eff = dist_rd[DW] ? dist_rd[DW-1:0] : dnext;
   assign psum   = {1'b0, path_rd} + {1'b0, pcur_ff};
   assign term   = qovf_ff ? DEP_MAX : quo_ff;
   assign dsum   = {1'b0, dep_nbr_ff} + {1'b0, term};
   assign csum   = (DEP_W + 1)'(cen_rd) + (DEP_W + 1)'(dep_cur_ff);

   // Configuration registers.
   always_comb begin
      numv_in  = numv_ff;
      first_in = first_ff;
      last_in  = last_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_NUM_VERTICES: numv_in  = csr_data[NUMV_W-1:0];
            REG_FIRST_SOURCE: first_in = csr_data[SRC_W-1:0];
            REG_LAST_SOURCE:  last_in  = csr_data[SRC_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state, datapath updates and memory controls.
   always_comb begin
      state_in      = state_ff;
      clr_run_in    = clr_run_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      step_in       = step_ff;
      ovf_in        = ovf_ff;
      cur_in        = cur_ff;
      nbr_in        = nbr_ff;
      dcur_in       = dcur_ff;
      pcur_in       = pcur_ff;
      dep_cur_in    = dep_cur_ff;
      dep_nbr_in    = dep_nbr_ff;
      k_in          = k_ff;
      hi_in         = hi_ff;
      mul_in        = mul_ff;
      opa_in        = opa_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      qovf_in       = qovf_ff;
      rd_vertex_in  = rd_vertex_ff;
      rd_inrange_in = rd_inrange_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      row_we = 1'b0;   row_waddr = RAW'(req_payload.index);  row_wdata = req_payload.value;
      row_re = 1'b0;   row_raddr = RAW'(cur_ff);
      edge_we = 1'b0;  edge_waddr = EW'(req_payload.index);  edge_wdata = req_payload.value;
      edge_re = 1'b0;  edge_raddr = EW'(k_ff);
      path_we = 1'b0;  path_waddr = VW'(cnt_ff);  path_wdata = '0;
      path_re = 1'b0;  path_raddr = cur_ff;
      dist_we = 1'b0;  dist_waddr = VW'(cnt_ff);  dist_wdata = '0;
      dist_re = 1'b0;  dist_raddr = cur_ff;
      dep_we = 1'b0;   dep_waddr = VW'(cnt_ff);   dep_wdata = '0;
      dep_re = 1'b0;   dep_raddr = cur_ff;
      order_we = 1'b0; order_waddr = VW'(tail_ff); order_wdata = nbr_ff;
      order_re = 1'b0; order_raddr = VW'(head_ff);
      cen_we = 1'b0;   cen_waddr = VW'(cnt_ff);   cen_wdata = '0;
      cen_re = 1'b0;   cen_raddr = VW'(req_payload.index);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_payload.cmd)
                  CMD_LOAD_OFFSET: row_we = (32'(req_payload.index) <= 32'(MAX_VERTICES));
                  CMD_LOAD_EDGE:   edge_we = (32'(req_payload.index) < 32'(MAX_EDGES));
                  CMD_RUN: begin
                     ovf_in     = 1'b0;
                     cnt_in     = '0;
                     clr_run_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  CMD_READ: begin
                     cen_re        = 1'b1;
                     rd_vertex_in  = req_payload.index[VERTEX_W-1:0];
                     rd_inrange_in = (32'(req_payload.index) < 32'(MAX_VERTICES));
                     state_in      = ST_READ;
                  end
                  default: ;
               endcase
            end
         end

         // Hand the read result over once the result register is free.
         ST_READ: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.vertex     = rd_vertex_ff;
               rsp_in.centrality = rd_inrange_ff ? cen_rd : '0;
               rsp_in.saturated  = ovf_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         // Clear the centrality store one entry per cycle.
         ST_CLEAR: begin
            cen_we = 1'b1;
            cnt_in = VCW'(cnt_ff + VCW'(1));
            if (32'(cnt_ff) == 32'(MAX_VERTICES - 1)) begin
               clr_run_in = 1'b0;
               src_in     = (SRC_W + 1)'(first_ff);
               if (clr_run_ff && (n_eff != '0)) begin
                  state_in = ST_SOURCE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Pick the next source in range, or finish.
         ST_SOURCE: begin
            cnt_in = '0;
            if (src_ff > (SRC_W + 1)'(last_ff)) begin
               state_in = ST_IDLE;
            end else if (32'(src_ff) >= 32'(n_eff)) begin
               src_in = (SRC_W + 1)'(src_ff + (SRC_W + 1)'(1));
            end else begin
               state_in = ST_INIT;
            end
         end

         // Clear counts, distances and dependencies of the first n vertices.
         ST_INIT: begin
            path_we = 1'b1;
            dist_we = 1'b1;
            dep_we  = 1'b1;
            cnt_in  = VCW'(cnt_ff + VCW'(1));
            if (cnt_ff == VCW'(n_eff - VCW'(1))) begin
               state_in = ST_SEED;
            end
         end

         // The source has one path, distance zero and opens the visit order.
         ST_SEED: begin
            path_we     = 1'b1;
            path_waddr  = VW'(src_ff);
            path_wdata  = CNT_W'(1);
            dist_we     = 1'b1;
            dist_waddr  = VW'(src_ff);
            dist_wdata  = {1'b1, DW'(0)};
            order_we    = 1'b1;
            order_waddr = '0;
            order_wdata = VW'(src_ff);
            head_in     = '0;
            tail_in     = VCW'(1);
            state_in    = ST_B_POP;
         end

         // Forward pass: take the next vertex in visit order.
         ST_B_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_R_POP;
            end else begin
               order_re = 1'b1;
               head_in  = VCW'(head_ff + VCW'(1));
               state_in = ST_B_VTX;
            end
         end

         ST_B_VTX: begin
            cur_in     = order_rd;
            row_re     = 1'b1;
            row_raddr  = RAW'(order_rd);
            dist_re    = 1'b1;
            dist_raddr = order_rd;
            path_re    = 1'b1;
            path_raddr = order_rd;
            state_in   = ST_B_LO;
         end

         ST_B_LO: begin
            k_in      = KW'(row_rd);
            dcur_in   = dist_rd[DW-1:0];
            pcur_in   = path_rd;
            row_re    = 1'b1;
            row_raddr = RAW'(RAW'(cur_ff) + RAW'(1));
            state_in  = ST_B_HI;
         end

         ST_B_HI: begin
            hi_in    = (32'(row_rd) > 32'(MAX_EDGES)) ? KW'(MAX_EDGES) : KW'(row_rd);
            state_in = ST_B_EDGE;
         end

         ST_B_EDGE: begin
            if (k_ff >= hi_ff) begin
               state_in = ST_B_POP;
            end else begin
               edge_re  = 1'b1;
               k_in     = KW'(k_ff + KW'(1));
               state_in = ST_B_NBR;
            end
         end

         ST_B_NBR: begin
            if (32'(edge_rd) >= 32'(n_eff)) begin
               state_in = ST_B_EDGE;
            end else begin
               nbr_in     = VW'(edge_rd);
               dist_re    = 1'b1;
               dist_raddr = VW'(edge_rd);
               path_re    = 1'b1;
               path_raddr = VW'(edge_rd);
               state_in   = ST_B_UPD;
            end
         end

         // Discover the neighbor and add paths along shortest-path edges.
         ST_B_UPD: begin
            if (!dist_rd[DW]) begin
               dist_we    = 1'b1;
               dist_waddr = nbr_ff;
               dist_wdata = {1'b1, dnext};
               order_we   = 1'b1;
               tail_in    = VCW'(tail_ff + VCW'(1));
            end
            if (dw_eff == dnext) begin
               path_we    = 1'b1;
               path_waddr = nbr_ff;
               if (psum[CNT_W]) begin
                  path_wdata = CNT_MAX;
                  ovf_in     = 1'b1;
               end else begin
                  path_wdata = psum[CNT_W-1:0];
               end
            end
            state_in = ST_B_EDGE;
         end

         // Reverse pass: walk the visit order backwards.
         ST_R_POP: begin
            if (tail_ff == '0) begin
               src_in   = (SRC_W + 1)'(src_ff + (SRC_W + 1)'(1));
               state_in = ST_SOURCE;
            end else begin
               order_re    = 1'b1;
               order_raddr = VW'(tail_ff - VCW'(1));
               tail_in     = VCW'(tail_ff - VCW'(1));
               state_in    = ST_R_VTX;
            end
         end

         ST_R_VTX: begin
            cur_in     = order_rd;
            row_re     = 1'b1;
            row_raddr  = RAW'(order_rd);
            dist_re    = 1'b1;
            dist_raddr = order_rd;
            path_re    = 1'b1;
            path_raddr = order_rd;
            dep_re     = 1'b1;
            dep_raddr  = order_rd;
            state_in   = ST_R_LO;
         end

         ST_R_LO: begin
            k_in       = KW'(row_rd);
            dcur_in    = dist_rd[DW-1:0];
            pcur_in    = path_rd;
            dep_cur_in = dep_rd;
            row_re     = 1'b1;
            row_raddr  = RAW'(RAW'(cur_ff) + RAW'(1));
            state_in   = ST_R_HI;
         end

         ST_R_HI: begin
            hi_in    = (32'(row_rd) > 32'(MAX_EDGES)) ? KW'(MAX_EDGES) : KW'(row_rd);
            state_in = ST_R_EDGE;
         end

         ST_R_EDGE: begin
            if (k_ff >= hi_ff) begin
               state_in = ST_R_CEN;
            end else begin
               edge_re  = 1'b1;
               k_in     = KW'(k_ff + KW'(1));
               state_in = ST_R_NBR;
            end
         end

         ST_R_NBR: begin
            if (32'(edge_rd) >= 32'(n_eff)) begin
               state_in = ST_R_EDGE;
            end else begin
               nbr_in     = VW'(edge_rd);
               dist_re    = 1'b1;
               dist_raddr = VW'(edge_rd);
               path_re    = 1'b1;
               path_raddr = VW'(edge_rd);
               dep_re     = 1'b1;
               dep_raddr  = VW'(edge_rd);
               state_in   = ST_R_CHK;
            end
         end

         // Only a visited predecessor one level closer to the source takes a share.
         ST_R_CHK: begin
            if (!dist_rd[DW] || (dcur_ff == '0) ||
                (dist_rd[DW-1:0] != DW'(dcur_ff - DW'(1)))) begin
               state_in = ST_R_EDGE;
            end else begin
               mul_in     = path_rd;
               opa_in     = FIX_ONE + OPA_W'(dep_cur_ff);
               dep_nbr_in = dep_rd;
               state_in   = ST_MUL0;
            end
         end

         ST_MUL0: begin
            prod_in  = PROD_W'(mprod);
            state_in = ST_MUL1;
         end

         ST_MUL1: begin
            prod_in  = PROD_W'(prod_ff + (PROD_W'(mprod) << CNT_W));
            rem_in   = '0;
            quo_in   = '0;
            qovf_in  = 1'b0;
            step_in  = '0;
            state_in = ST_DIV;
         end

         // Quotient bits above the dependency width mark saturation.
         ST_DIV: begin
            rem_in  = div_ge ? CNT_W'(div_trial - {1'b0, pcur_ff}) : div_trial[CNT_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            quo_in  = {quo_ff[DEP_W-2:0], div_ge};
            qovf_in = qovf_ff | quo_ff[DEP_W-1];
            step_in = STEP_W'(step_ff + STEP_W'(1));
            if (32'(step_ff) == 32'(PROD_W - 1)) begin
               state_in = ST_ACC;
            end
         end

         ST_ACC: begin
            dep_we    = 1'b1;
            dep_waddr = nbr_ff;
            if (dsum[DEP_W]) begin
               dep_wdata = DEP_MAX;
               ovf_in    = 1'b1;
            end else begin
               dep_wdata = dsum[DEP_W-1:0];
               ovf_in    = ovf_ff | qovf_ff;
            end
            state_in = ST_R_EDGE;
         end

         // Every vertex but the source adds its dependency into its centrality.
         ST_R_CEN: begin
            if (cur_ff != VW'(src_ff)) begin
               cen_re    = 1'b1;
               cen_raddr = cur_ff;
               state_in  = ST_R_CENW;
            end else begin
               state_in = ST_R_POP;
            end
         end

         ST_R_CENW: begin
            cen_we    = 1'b1;
            cen_waddr = cur_ff;
            if (csum > (DEP_W + 1)'(CEN_MAX)) begin
               cen_wdata = CEN_MAX;
               ovf_in    = 1'b1;
            end else begin
               cen_wdata = csum[CENT_W-1:0];
            end
            state_in = ST_R_POP;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state with synchronous reset; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_run_ff   <= 1'b0;
         cnt_ff       <= '0;
         src_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         step_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         numv_ff      <= NUMV_W'(1024);
         first_ff     <= '0;
         last_ff      <= SRC_W'(1023);
      end else begin
         state_ff     <= state_in;
         clr_run_ff   <= clr_run_in;
         cnt_ff       <= cnt_in;
         src_ff       <= src_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         step_ff      <= step_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         numv_ff      <= numv_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      nbr_ff        <= nbr_in;
      dcur_ff       <= dcur_in;
      pcur_ff       <= pcur_in;
      dep_cur_ff    <= dep_cur_in;
      dep_nbr_ff    <= dep_nbr_in;
      k_ff          <= k_in;
      hi_ff         <= hi_in;
      mul_ff        <= mul_in;
      opa_ff        <= opa_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      qovf_ff       <= qovf_in;
      rd_vertex_ff  <= rd_vertex_in;
      rd_inrange_ff <= rd_inrange_in;
      rsp_ff        <= rsp_in;
   end

   // Graph and per-vertex stores.
   bce_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_VERTICES + 1)) u_row_ram (
      .clock(clock), .wr_en(row_we), .wr_addr(row_waddr), .wr_data(row_wdata),
      .rd_en(row_re), .rd_addr(row_raddr), .rd_data(row_rd)
   );

   bce_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(edge_wdata),
      .rd_en(edge_re), .rd_addr(edge_raddr), .rd_data(edge_rd)
   );

   bce_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_path_ram (
      .clock(clock), .wr_en(path_we), .wr_addr(path_waddr), .wr_data(path_wdata),
      .rd_en(path_re), .rd_addr(path_raddr), .rd_data(path_rd)
   );

   bce_ram #(.WIDTH(DW + 1), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_waddr), .wr_data(dist_wdata),
      .rd_en(dist_re), .rd_addr(dist_raddr), .rd_data(dist_rd)
   );

   bce_ram #(.WIDTH(DEP_W), .DEPTH(MAX_VERTICES)) u_dep_ram (
      .clock(clock), .wr_en(dep_we), .wr_addr(dep_waddr), .wr_data(dep_wdata),
      .rd_en(dep_re), .rd_addr(dep_raddr), .rd_data(dep_rd)
   );

   bce_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_order_ram (
      .clock(clock), .wr_en(order_we), .wr_addr(order_waddr), .wr_data(order_wdata),
      .rd_en(order_re), .rd_addr(order_raddr), .rd_data(order_rd)
   );

   bce_ram #(.WIDTH(CENT_W), .DEPTH(MAX_VERTICES)) u_cen_ram (
      .clock(clock), .wr_en(cen_we), .wr_addr(cen_waddr), .wr_data(cen_wdata),
      .rd_en(cen_re), .rd_addr(cen_raddr), .rd_data(cen_rd)
   );

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the betweenness centrality engine top level.
`timescale 1ns / 1ps
module testbench;
   import bce_pkg::*;

   localparam int NV         = DEF_MAX_VERTICES;
   localparam int NE         = DEF_MAX_EDGES;
   localparam int GRAPH_V    = 16;
   localparam int STALL_LIMIT = 300000;
   localparam logic [127:0] FIX_ONE = 128'd1 << DEF_FRAC_BITS;

   // One item to send, with an optional expectation typed in by hand.
   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } stim_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   betweenness_centrality_engine_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Predictor state.
   logic [NUMV_W-1:0]  cfg_vertices;
   logic [SRC_W-1:0]   cfg_first;
   logic [SRC_W-1:0]   cfg_last;
   logic [VALUE_W-1:0] row_mem [0:NV];
   logic [VALUE_W-1:0] edge_mem [0:NE-1];
   logic [CNT_W-1:0]   paths [0:NV-1];
   int                 level [0:NV-1];
   bit                 seen [0:NV-1];
   logic [DEP_W-1:0]   depend [0:NV-1];
   int                 order [0:NV-1];
   logic [CENT_W-1:0]  score [0:NV-1];
   bit                 sat_flag;

   stim_type pending_items[$];
   rsp_type  expected_reads[$];
   stim_type cur_item;
   bit       req_taken;
   bit       rsp_taken;
   bit       quiet;
   int       req_gap;
   int       stall_gap;
   int       errors;
   int       idle_cycles;

   // Row range of a vertex, with the end cut to the edge store size.
   task automatic row_range(input int v, output int lo, output int hi);
      lo = row_mem[v];
      hi = row_mem[v + 1];
      if (hi > NE) hi = NE;
   endtask

   // One breadth-first pass from a source and its reverse accumulation.
   task automatic centrality_source(input int s, input int n);
      int head, tail, v, w, k, lo, hi;
      logic [32:0]  sum;
      logic [127:0] quo;
      logic [40:0]  dsum;
      logic [36:0]  csum;
      for (int i = 0; i < n; i++) begin
         paths[i] = '0;
         level[i] = 0;
         seen[i] = 1'b0;
         depend[i] = '0;
      end
      head = 0;
      tail = 0;
      paths[s] = 1;
      seen[s] = 1'b1;
      order[tail++] = s;
      while (head < tail) begin
         v = order[head++];
         row_range(v, lo, hi);
         for (k = lo; k < hi; k++) begin
            w = edge_mem[k];
            if (w >= n) continue;
            if (!seen[w]) begin
               seen[w] = 1'b1;
               level[w] = level[v] + 1;
               order[tail++] = w;
            end
            if (level[w] == level[v] + 1) begin
               sum = {1'b0, paths[w]} + {1'b0, paths[v]};
               if (sum > {1'b0, CNT_MAX}) begin
                  sum = {1'b0, CNT_MAX};
                  sat_flag = 1'b1;
               end
               paths[w] = sum[CNT_W-1:0];
            end
         end
      end
      while (tail > 0) begin
         w = order[--tail];
         row_range(w, lo, hi);
         for (k = lo; k < hi; k++) begin
            v = edge_mem[k];
            if (v >= n || !seen[v]) continue;
            if (level[w] != 0 && level[v] == level[w] - 1) begin
               quo = (128'(paths[v]) * (FIX_ONE + 128'(depend[w]))) / 128'(paths[w]);
               if (quo > 128'(DEP_MAX)) begin
                  quo = 128'(DEP_MAX);
                  sat_flag = 1'b1;
               end
               dsum = {1'b0, depend[v]} + {1'b0, quo[DEP_W-1:0]};
               if (dsum > {1'b0, DEP_MAX}) begin
                  dsum = {1'b0, DEP_MAX};
                  sat_flag = 1'b1;
               end
               depend[v] = dsum[DEP_W-1:0];
            end
         end
         if (w != s) begin
            csum = {1'b0, score[w]} + {1'b0, depend[w][CENT_W-1:0]};
            if (depend[w] > DEP_W'(CEN_MAX) || csum > {1'b0, CEN_MAX}) begin
               csum = {1'b0, CEN_MAX};
               sat_flag = 1'b1;
            end
            score[w] = csum[CENT_W-1:0];
         end
      end
   endtask

   // Applies one accepted item to the predictor state; returns 1 for a read.
   task automatic apply_item(input req_type it, output bit has_rsp, output rsp_type r);
      int n;
      has_rsp = 1'b0;
      r = '0;
      case (it.cmd)
         CMD_LOAD_OFFSET: begin
            if (it.index <= NV) row_mem[it.index] = it.value;
         end
         CMD_LOAD_EDGE: begin
            if (it.index < NE) edge_mem[it.index] = it.value;
         end
         CMD_RUN: begin
            for (int i = 0; i < NV; i++) score[i] = '0;
            sat_flag = 1'b0;
            n = cfg_vertices;
            if (n > NV) n = NV;
            if (n != 0) begin
               for (int s = cfg_first; s <= cfg_last; s++) begin
                  if (s < n) centrality_source(s, n);
               end
            end
         end
         default: begin
            has_rsp = 1'b1;
            r.vertex = it.index[VERTEX_W-1:0];
            r.centrality = (it.index < NV) ? score[it.index] : '0;
            r.saturated = sat_flag;
         end
      endcase
   endtask

   function automatic stim_type mk(logic [CMD_W-1:0] c, int idx, int val);
      stim_type t;
      t.item.cmd = c;
      t.item.index = INDEX_W'(idx);
      t.item.value = VALUE_W'(val);
      t.fixed = 1'b0;
      t.want = '0;
      return t;
   endfunction

   function automatic stim_type mk_read(int idx, int vtx, longint cent, bit sat);
      stim_type t;
      t = mk(CMD_READ, idx, 0);
      t.fixed = 1'b1;
      t.want.vertex = VERTEX_W'(vtx);
      t.want.centrality = CENT_W'(cent);
      t.want.saturated = sat;
      return t;
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: predict on each accepted item, check each accepted result.
   always @(posedge clock) begin
      bit      has_rsp;
      rsp_type r, e;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (req_taken) begin
         apply_item(req_payload, has_rsp, r);
         if (has_rsp) expected_reads.push_back(cur_item.fixed ? cur_item.want : r);
      end
      if (rsp_taken) begin
         if (expected_reads.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $realtime, rsp_payload);
            errors++;
         end else begin
            e = expected_reads.pop_front();
            if (rsp_payload.vertex !== e.vertex) begin
               $display("%0t: vertex mismatch, expected %0d actual %0d",
                        $realtime, e.vertex, rsp_payload.vertex);
               errors++;
            end
            if (rsp_payload.centrality !== e.centrality) begin
               $display("%0t: centrality mismatch, expected %0d actual %0d",
                        $realtime, e.centrality, rsp_payload.centrality);
               errors++;
            end
            if (rsp_payload.saturated !== e.saturated) begin
               $display("%0t: saturated mismatch, expected %0d actual %0d",
                        $realtime, e.saturated, rsp_payload.saturated);
               errors++;
            end
         end
      end
      // Watchdog on cycles without any transfer.
      if (req_taken || rsp_taken || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Request driver with random idle bursts.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else begin
               cur_item = pending_items.pop_front();
               req_payload <= cur_item.item;
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall in random bursts.
   always @(negedge clock) begin
      if (stall_gap > 0) begin
         stall_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_gap = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Register write, applied to the predictor at the same time.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      if (idx == REG_NUM_VERTICES) cfg_vertices = NUMV_W'(val);
      else if (idx == REG_FIRST_SOURCE) cfg_first = SRC_W'(val);
      else if (idx == REG_LAST_SOURCE) cfg_last = SRC_W'(val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every item is sent and every read has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_reads.size() != 0);
      repeat (16) @(negedge clock);
   endtask

   // Random graph on the low vertices; targets stay low or beyond every vertex count.
   task automatic load_random_graph();
      int rows [0:GRAPH_V];
      int e, deg, t;
      e = 0;
      for (int v = 0; v < GRAPH_V; v++) begin
         rows[v] = e;
         deg = $urandom_range(0, 3);
         for (int j = 0; j < deg; j++) begin
            if ($urandom_range(0, 9) == 0) t = $urandom_range(NV, 16383);
            else t = $urandom_range(0, GRAPH_V - 1);
            pending_items.push_back(mk(CMD_LOAD_EDGE, e, t));
            e++;
         end
      end
      rows[GRAPH_V] = e;
      // Sometimes pull one offset down so that a row range runs backward.
      if ($urandom_range(0, 2) == 0 && e > 0) begin
         t = $urandom_range(1, GRAPH_V - 1);
         rows[t] = $urandom_range(0, rows[t]);
      end
      for (int v = 0; v <= GRAPH_V; v++) begin
         pending_items.push_back(mk(CMD_LOAD_OFFSET, v, rows[v]));
         if ($urandom_range(0, 3) == 0) push_noise();
      end
   endtask

   // Loads to slots that no run ever reads, or that the block ignores.
   task automatic push_noise();
      case ($urandom_range(0, 2))
         0: pending_items.push_back(mk(CMD_LOAD_OFFSET, $urandom_range(GRAPH_V + 1, NV - 2),
                                       $urandom_range(0, 16383)));
         1: pending_items.push_back(mk(CMD_LOAD_OFFSET, $urandom_range(NV + 1, 8191),
                                       $urandom_range(0, 16383)));
         default: pending_items.push_back(mk(CMD_LOAD_EDGE, $urandom_range(256, 8191),
                                             $urandom_range(0, 16383)));
      endcase
   endtask

   // A chain with many parallel edges so that path counts saturate.
   task automatic load_chain_graph();
      for (int k = 0; k < 144; k++) pending_items.push_back(mk(CMD_LOAD_EDGE, k, k / 16 + 1));
      for (int v = 0; v <= GRAPH_V; v++)
         pending_items.push_back(mk(CMD_LOAD_OFFSET, v, (v <= 9) ? 16 * v : 144));
   endtask

   // Random vertex count and source range, kept off unloaded rows.
   task automatic random_settings();
      int n, f, l;
      case ($urandom_range(0, 7))
         0: n = 0;
         1: n = 1;
         2: n = NV;
         3: n = 2047;
         4: n = GRAPH_V;
         default: n = $urandom_range(2, GRAPH_V);
      endcase
      f = $urandom_range(0, GRAPH_V - 1);
      l = $urandom_range(f, (f + 4 < GRAPH_V) ? f + 4 : GRAPH_V - 1);
      case ($urandom_range(0, 7))
         0: begin
            f = NV - 1;
            l = NV - 1;
         end
         1: begin
            l = f;
            f = $urandom_range(f, GRAPH_V - 1);
            if (f == l) f = l + 1;
         end
         2: if (n <= GRAPH_V) l = NV - 1;
         default: ;
      endcase
      write_reg(REG_NUM_VERTICES, n);
      write_reg(REG_FIRST_SOURCE, f);
      write_reg(REG_LAST_SOURCE, l);
   endtask

   task automatic push_reads(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0)
            pending_items.push_back(mk(CMD_READ, $urandom_range(0, 8191), $urandom_range(0, 16383)));
         else
            pending_items.push_back(mk(CMD_READ, $urandom_range(0, GRAPH_V - 1),
                                       $urandom_range(0, 16383)));
      end
   endtask

   initial begin
      stim_type directed_rows[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_vertices = NUMV_W'(NV);
      cfg_first = '0;
      cfg_last = SRC_W'(NV - 1);
      sat_flag = 1'b0;
      for (int i = 0; i <= NV; i++) row_mem[i] = '0;
      for (int i = 0; i < NE; i++) edge_mem[i] = '0;
      for (int i = 0; i < NV; i++) score[i] = '0;
      quiet = 1'b0;
      req_gap = 0;
      stall_gap = 0;
      errors = 0;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: a three-vertex path whose middle vertex lies on two paths.
      write_reg(REG_NUM_VERTICES, 3);
      directed_rows.push_back(mk_read(0, 0, 0, 0));
      directed_rows.push_back(mk_read(8191, 1023, 0, 0));
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, 0, 0));
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, 1, 1));
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, 2, 3));
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, 3, 4));
      directed_rows.push_back(mk(CMD_LOAD_EDGE, 0, 1));
      directed_rows.push_back(mk(CMD_LOAD_EDGE, 1, 0));
      directed_rows.push_back(mk(CMD_LOAD_EDGE, 2, 2));
      directed_rows.push_back(mk(CMD_LOAD_EDGE, 3, 1));
      // Highest offset slots hold an end below the start, so that row is empty.
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, NV - 1, 16383));
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, NV, 16383));
      // Offset slots out of range are ignored; edge slot 8191 is the last one in range and is written.
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, 8191, 16383));
      directed_rows.push_back(mk(CMD_LOAD_OFFSET, NV + 1, 5));
      directed_rows.push_back(mk(CMD_LOAD_EDGE, 8191, 16383));
      directed_rows.push_back(mk(CMD_RUN, 0, 0));
      directed_rows.push_back(mk_read(1, 1, 2 << DEF_FRAC_BITS, 0));
      directed_rows.push_back(mk_read(0, 0, 0, 0));
      directed_rows.push_back(mk_read(2, 2, 0, 0));
      directed_rows.push_back(mk_read(8191, 1023, 0, 0));
      directed_rows.push_back(mk(CMD_READ, 5, 16383));
      foreach (directed_rows[i]) pending_items.push_back(directed_rows[i]);
      wait_drained();

      // Random phases: settings while idle, then graph loads, a run and reads of the result.
      for (int phase = 0; phase < 20; phase++) begin
         if (phase == 3) begin
            write_reg(REG_NUM_VERTICES, GRAPH_V);
            write_reg(REG_FIRST_SOURCE, 0);
            write_reg(REG_LAST_SOURCE, 0);
            load_chain_graph();
         end else begin
            random_settings();
            if (phase == 0 || phase == 4 || $urandom_range(0, 2) == 0) load_random_graph();
         end
         if (phase >= 16) quiet = 1'b1;
         push_reads($urandom_range(0, 2));
         push_noise();
         pending_items.push_back(mk(CMD_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383)));
         push_reads($urandom_range(6, 14));
         wait_drained();
      end

      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
